FILE: design/tfj_pkg.sv
// Shared types and constants for the text full justifier.
`timescale 1ns / 1ps

package tfj_pkg;

   // Widths of the fixed payload and register fields.
   localparam int CHAR_W = 8;
   localparam int CFG_W = 6;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Register index of the line width register.
   localparam logic [0:0] REG_MAX_WIDTH = 1'b0;

   // Character used for all padding and gaps.
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

   // Line width after reset, before clamping.
   localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd16;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PREP,
      ST_EMIT,
      ST_COPY,
      ST_FINISH
   } state_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: design/tfj_req_if.sv
// Input and result channel interfaces of the text full justifier.
`timescale 1ns / 1ps

interface tfj_req_if;
   logic                      valid;
   logic                      ready;
   logic [tfj_pkg::CHAR_W-1:0] ch;
   logic                      word_end;
   logic                      text_end;

   modport source (output valid, ch, word_end, text_end, input ready);
   modport sink (input valid, ch, word_end, text_end, output ready);
endinterface

interface tfj_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tfj_pkg::CHAR_W-1:0] out_char;
   logic                      line_end;
   logic                      clipped;

   modport source (output valid, out_char, line_end, clipped, input ready);
   modport sink (input valid, out_char, line_end, clipped, output ready);
endinterface

FILE: design/text_full_justifier_top.sv
// Top level of the greedy text full justifier.
//
//  Port      Dir  Content
//  req       in   one word character per word, with word_end and text_end
//  rsp       out  one output line character per word, with line_end, clipped
//  psel/...  in   register 0 at byte 0: max_width, clamped to 1..MAX_WIDTH
//
// A character that does not end a word is taken in the idle state. A word end
// is checked against the pending line and the word is then appended to it.
// Emitting a line takes the ST_PREP setup state and then max_width characters,
// and a justified line first waits in the subtract-once-per-cycle divider. Reset is
// synchronous and clears the pending line; rsp stalls hold the sequencer in
// its emit state.
`timescale 1ns / 1ps

module text_full_justifier_top #(
   parameter int MAX_WIDTH = 32,
   parameter int MAX_WORDS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   tfj_req_if.sink                        req,
   tfj_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tfj_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [tfj_pkg::APB_DATA_W-1:0] pwdata,
   output logic [tfj_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int PW  = $clog2(MAX_WIDTH);
   localparam int WCW = $clog2(MAX_WORDS + 1);
   localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int SW  = $clog2(2 * MAX_WIDTH + MAX_WORDS + 1);

   tfj_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  width;
   logic           clear;

   logic [tfj_pkg::CHAR_W-1:0] word_mem [MAX_WIDTH];
   logic [tfj_pkg::CHAR_W-1:0] line_mem [MAX_WIDTH];
   logic [CW-1:0]              len_mem  [MAX_WORDS];

   logic [CW-1:0]  cur_ff;
   logic           clip_ff;
   logic           te_ff;
   logic [WCW-1:0] words_ff;
   logic [CW-1:0]  letters_ff;
   logic           line_clip_ff;
   logic           left_ff;
   logic [CW-1:0]  even_ff;
   logic [CW-1:0]  extra_ff;
   logic [WIW-1:0] k_ff;
   logic [CW-1:0]  rem_ff;
   logic [CW-1:0]  gap_ff;
   logic [CW-1:0]  src_ff;
   logic [CW-1:0]  pos_ff;
   logic [CW-1:0]  cp_ff;

   logic                       rsp_valid_ff;
   logic [tfj_pkg::CHAR_W-1:0] out_char_ff;
   logic                       line_end_ff;
   logic                       clipped_ff;

   logic                    accept;
   logic                    flush;
   logic [SW-1:0]           need;
   logic                    div_start;
   logic [CW-1:0]           div_quo;
   logic [CW-1:0]           div_rem;
   logic [WCW-1:0]          div_den;
   tfj_pkg::div_status_type div_status;
   logic                    emit_step;
   logic                    emit_last;
   logic                    copy_last;
   logic                    more_words;
   logic [WIW-1:0]          k_next;

   // Register block.
   tfj_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .width   (width),
      .clear   (clear)
   );

   // Divider spreads the free spaces over the gaps.
   assign div_den = (words_ff > WCW'(1)) ? (words_ff - WCW'(1)) : WCW'(1);

   tfj_divider #(.NUM_W(CW), .DEN_W(WCW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (width - letters_ff),
      .divisor   (div_den),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   // Fit test of the completed word against the pending line.
   assign need  = SW'(letters_ff) + SW'(words_ff) + SW'(cur_ff);
   assign flush = (words_ff != '0) &&
                  ((need > SW'(width)) || (words_ff >= WCW'(MAX_WORDS)));

   assign accept     = req.valid && req.ready;
   assign emit_last  = pos_ff == (width - CW'(1));
   assign copy_last  = cp_ff == (cur_ff - CW'(1));
   assign k_next     = k_ff + WIW'(1);
   assign more_words = (WCW'(k_ff) + WCW'(1)) < words_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfj_pkg::ST_IDLE: begin
            if (accept && req.word_end) state_in = tfj_pkg::ST_CHECK;
         end
         tfj_pkg::ST_CHECK: begin
            state_in = flush ? tfj_pkg::ST_DIV_START : tfj_pkg::ST_COPY;
         end
         tfj_pkg::ST_DIV_START: state_in = tfj_pkg::ST_DIV_WAIT;
         tfj_pkg::ST_DIV_WAIT: begin
            if (div_status.done) state_in = tfj_pkg::ST_PREP;
         end
         tfj_pkg::ST_PREP: state_in = tfj_pkg::ST_EMIT;
         tfj_pkg::ST_EMIT: begin
            if (emit_step && emit_last) begin
               state_in = left_ff ? tfj_pkg::ST_IDLE : tfj_pkg::ST_COPY;
            end
         end
         tfj_pkg::ST_COPY: begin
            if (copy_last) state_in = tfj_pkg::ST_FINISH;
         end
         tfj_pkg::ST_FINISH: begin
            state_in = te_ff ? tfj_pkg::ST_PREP : tfj_pkg::ST_IDLE;
         end
         default: state_in = tfj_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req.ready = 1'b0;
      div_start = 1'b0;
      emit_step = 1'b0;
      case (state_ff)
         tfj_pkg::ST_IDLE:      req.ready = 1'b1;
         tfj_pkg::ST_DIV_START: div_start = 1'b1;
         tfj_pkg::ST_EMIT:      emit_step = !rsp_valid_ff || rsp.ready;
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfj_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Line bookkeeping.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cur_ff       <= '0;
         clip_ff      <= 1'b0;
         words_ff     <= '0;
         letters_ff   <= '0;
         line_clip_ff <= 1'b0;
      end else begin
         case (state_ff)
            tfj_pkg::ST_IDLE: begin
               if (accept) begin
                  if (cur_ff < width) begin
                     cur_ff <= cur_ff + CW'(1);
                  end else begin
                     clip_ff <= 1'b1;
                  end
               end
            end
            tfj_pkg::ST_EMIT: begin
               if (emit_step && emit_last) begin
                  words_ff     <= '0;
                  letters_ff   <= '0;
                  line_clip_ff <= 1'b0;
               end
            end
            tfj_pkg::ST_FINISH: begin
               words_ff     <= words_ff + WCW'(1);
               letters_ff   <= letters_ff + cur_ff;
               line_clip_ff <= line_clip_ff | clip_ff;
               cur_ff       <= '0;
               clip_ff      <= 1'b0;
            end
            default: begin
               cur_ff <= cur_ff;
            end
         endcase
      end
   end

   // Word, line and length stores, and the emit counters.
   always_ff @(posedge clock) begin
      case (state_ff)
         tfj_pkg::ST_IDLE: begin
            if (accept) begin
               te_ff <= req.text_end;
               if (cur_ff < width) word_mem[cur_ff[PW-1:0]] <= req.ch;
            end
         end
         tfj_pkg::ST_CHECK: begin
            left_ff <= 1'b0;
            cp_ff   <= '0;
         end
         tfj_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               even_ff  <= div_quo;
               extra_ff <= div_rem;
            end
         end
         tfj_pkg::ST_PREP: begin
            k_ff   <= '0;
            rem_ff <= len_mem[0];
            gap_ff <= '0;
            src_ff <= '0;
            pos_ff <= '0;
         end
         tfj_pkg::ST_EMIT: begin
            if (emit_step) begin
               pos_ff <= pos_ff + CW'(1);
               cp_ff  <= '0;
               if (gap_ff != '0) begin
                  gap_ff <= gap_ff - CW'(1);
               end else if (rem_ff != '0) begin
                  src_ff <= src_ff + CW'(1);
                  if (rem_ff == CW'(1) && more_words) begin
                     k_ff   <= k_next;
                     rem_ff <= len_mem[k_next];
                     gap_ff <= even_ff + CW'(extra_ff != '0);
                     if (extra_ff != '0) extra_ff <= extra_ff - CW'(1);
                  end else begin
                     rem_ff <= rem_ff - CW'(1);
                  end
               end
            end
         end
         tfj_pkg::ST_COPY: begin
            line_mem[PW'(letters_ff + cp_ff)] <= word_mem[cp_ff[PW-1:0]];
            cp_ff <= cp_ff + CW'(1);
         end
         tfj_pkg::ST_FINISH: begin
            if (words_ff < WCW'(MAX_WORDS)) len_mem[words_ff[WIW-1:0]] <= cur_ff;
            left_ff  <= 1'b1;
            even_ff  <= CW'(1);
            extra_ff <= '0;
         end
         default: begin
            cp_ff <= cp_ff;
         end
      endcase
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The line store is read here at the current source position; gaps and padding are spaces.
   always_ff @(posedge clock) begin
      if (emit_step) begin
         if (gap_ff == '0 && rem_ff != '0) begin
            out_char_ff <= line_mem[src_ff[PW-1:0]];
         end else begin
            out_char_ff <= tfj_pkg::SPACE_CHAR;
         end
         line_end_ff <= emit_last;
         clipped_ff  <= line_clip_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_char = out_char_ff;
   assign rsp.line_end = line_end_ff;
   assign rsp.clipped  = clipped_ff;

   // The pending line never holds more words than the length store.
   a_words_bound: assert property (@(posedge clock) disable iff (reset)
      int'(words_ff) <= MAX_WORDS)
      else $error("pending line holds too many words");

   // Emission stops at the line width.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfj_pkg::ST_EMIT) |-> (pos_ff < width))
      else $error("emit position ran past the line width");

   // Copying a word stays inside the line store.
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfj_pkg::ST_COPY) |-> (int'(letters_ff) + int'(cp_ff) < MAX_WIDTH))
      else $error("word copy ran past the line store");

endmodule

FILE: design/tfj_csr.sv
// Configuration register block holding the clamped line width.
`timescale 1ns / 1ps

module tfj_csr #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tfj_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [tfj_pkg::APB_DATA_W-1:0] pwdata,
   output logic [tfj_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0] width,
   output logic                           clear
);

   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0] width_ff;
   logic [CW-1:0] width_in;
   logic          wr_hit;

   // Clamp a raw register value to 1..MAX_WIDTH.
   function automatic logic [CW-1:0] clamp(input logic [tfj_pkg::CFG_W-1:0] v);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (int'(v) > MAX_WIDTH) begin
         r = CW'(MAX_WIDTH);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   // A write lands when the access phase completes at the width register.
   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite &&
                   (paddr[tfj_pkg::APB_ADDR_W-1] == tfj_pkg::REG_MAX_WIDTH);
   assign width_in = clamp(pwdata[tfj_pkg::CFG_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= clamp(tfj_pkg::WIDTH_RESET);
      end else if (wr_hit) begin
         width_ff <= width_in;
      end
   end

   // Read back the width where the top address bit is clear; other addresses read as zero.
   always_comb begin
      prdata = '0;
      if (paddr[tfj_pkg::APB_ADDR_W-1] == tfj_pkg::REG_MAX_WIDTH) begin
         prdata = tfj_pkg::APB_DATA_W'(width_ff);
      end
   end

   assign width = width_ff;
   assign clear = wr_hit;

endmodule

FILE: design/tfj_divider.sv
// Shared iterative divider that subtracts the divisor once per cycle.
`timescale 1ns / 1ps

module tfj_divider #(
   parameter int NUM_W = 6,
   parameter int DEN_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_W-1:0]        dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic [NUM_W-1:0]        quotient,
   output logic [NUM_W-1:0]        remainder,
   output tfj_pkg::div_status_type status
);

   logic             busy_ff;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] den_ff;
   logic             fits;

   assign fits = rem_ff >= den_ff;

   // One subtraction per cycle until the remainder drops below the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && !fits) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         quo_ff <= '0;
         den_ff <= NUM_W'(divisor);
      end else if (busy_ff && fits) begin
         rem_ff <= rem_ff - den_ff;
         quo_ff <= quo_ff + NUM_W'(1);
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = busy_ff && !fits;

   // The result is only reported once the remainder is reduced.
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (rem_ff < den_ff))
      else $error("divider reported done with remainder not below divisor");

endmodule
